>>> rtl/lbdmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbdmc_pkg: shared types and constants
// Sizes, field layout and slot entry format for the line bounds cache.
// ----------------------------------------------------------------------------
package lbdmc_pkg;

  localparam int MAX_SLOTS    = 2048;
  localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
  localparam int LINE_BITS    = 24;
  localparam int SCAN_BITS    = 8;
  localparam int COL_BITS     = 9;
  localparam int COUNT_BITS   = 12;
  localparam int MODE_BITS    = 2;

  // remainder unit: bits of the line number consumed per cycle
  localparam int DIV_STEP     = 4;
  localparam int DIV_CYCLES   = LINE_BITS / DIV_STEP;
  localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

  localparam int IN_DATA_BITS  = 104;
  localparam int OUT_DATA_BITS = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_RANGE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                 valid;
    logic [LINE_BITS-1:0] line;
    logic [SCAN_BITS-1:0] scan;
    logic [COL_BITS-1:0]  first;
    logic [COL_BITS-1:0]  last;
  } entry_t;

endpackage : lbdmc_pkg
`default_nettype wire

>>> rtl/line_bounds_direct_mapped_cache_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_bounds_direct_mapped_cache_unit
// Direct-mapped cache of first/last non-blank column per document line.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup runs the line-mod-slot_count
// remainder unit (4 bits per cycle), one memory read, one compare/write-back
// step, the result load and the return to idle. With slot_count zero a lookup
// bypasses the store: it returns the supplied bounds with hit 0, going from
// idle straight to its result state. A range invalidation walks slots
// 0..slot_count-1 through the single-port-read memory at one slot per cycle.
// A no-op goes from idle straight to its result state. A clear does the same,
// then sweeps all 2048 entries with s_axis_tready low. The same sweep runs
// after reset and after every slot_count write. An untaken result holds the
// next item in its result state for as long as the sink stalls.
// ----------------------------------------------------------------------------
module line_bounds_direct_mapped_cache_unit
  import lbdmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // config
  input  wire logic                     cfg_wr_en,
  input  wire logic [COUNT_BITS-1:0]    cfg_wr_data,   // slot_count
  // input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // line[23:0], scan[31:24], fill_first[40:32],
  // fill_last[49:41], range_first_line[73:50], range_last_line[97:74]
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  input  wire logic [MODE_BITS-1:0]     s_axis_tuser,  // mode[1:0]
  // result stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // hit[0], first_col[9:1], last_col[18:10], nonblank[19],
  // valid_count[31:20]
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_READ   = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_RESULT = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t                  state;
  logic [COUNT_BITS-1:0]   slot_count;
  logic [COUNT_BITS-1:0]   count;
  mode_t                   mode_q;

  logic [LINE_BITS-1:0]    line_q;
  logic [SCAN_BITS-1:0]    scan_q;
  logic [COL_BITS-1:0]     fill_first_q;
  logic [COL_BITS-1:0]     fill_last_q;
  logic [LINE_BITS-1:0]    range_lo;
  logic [LINE_BITS-1:0]    range_hi;

  logic [LINE_BITS-1:0]    div_line;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   rem_next;

  logic [COUNT_BITS-1:0]   walk_addr;
  logic                    walk_pend;
  logic [SLOT_BITS-1:0]    pend_addr;
  logic [SLOT_BITS-1:0]    clr_addr;

  logic                    res_hit;
  logic [COL_BITS-1:0]     res_first;
  logic [COL_BITS-1:0]     res_last;
  logic                    res_nonblank;
  logic                    out_load;

  entry_t                  mem [MAX_SLOTS];
  entry_t                  rd_q;
  entry_t                  wr_data;
  logic                    rd_en;
  logic                    mem_we;
  logic [SLOT_BITS-1:0]    rd_addr;
  logic [SLOT_BITS-1:0]    wr_addr;
  logic [SLOT_BITS-1:0]    slot_idx;

  // input unpack
  logic [LINE_BITS-1:0]    in_line;
  logic [SCAN_BITS-1:0]    in_scan;
  logic [COL_BITS-1:0]     in_first;
  logic [COL_BITS-1:0]     in_last;
  logic [LINE_BITS-1:0]    in_rfirst;
  logic [LINE_BITS-1:0]    in_rlast;
  mode_t                   in_mode;

  assign in_line   = s_axis_tdata[23:0];
  assign in_scan   = s_axis_tdata[31:24];
  assign in_first  = s_axis_tdata[40:32];
  assign in_last   = s_axis_tdata[49:41];
  assign in_rfirst = s_axis_tdata[73:50];
  assign in_rlast  = s_axis_tdata[97:74];
  assign in_mode   = mode_t'(s_axis_tuser);

  // a slot_count write takes the cycle, so no item is taken with it
  assign s_axis_tready = (state == S_IDLE) && !cfg_wr_en;
  assign slot_idx      = rem[SLOT_BITS-1:0];
  assign out_load      = (state == S_RESULT) && !cfg_wr_en &&
                         (!m_axis_tvalid || m_axis_tready);

  logic hit_now;
  logic walk_match;
  logic walk_more;

  assign hit_now    = rd_q.valid && (rd_q.line == line_q) && (rd_q.scan == scan_q);
  assign walk_more  = (walk_addr < slot_count);
  assign walk_match = walk_pend && rd_q.valid &&
                      (rd_q.line >= range_lo) && (rd_q.line <= range_hi);

  // restoring remainder, DIV_STEP bits of the line per cycle
  always_comb begin
    logic [COUNT_BITS-1:0] r;
    logic [COUNT_BITS-1:0] t;
    r = rem;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r[COUNT_BITS-2:0], div_line[LINE_BITS-1-i]};
      if (t >= slot_count) begin
        t = t - slot_count;
      end
      r = t;
    end
    rem_next = r;
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_idx;
    mem_we  = 1'b0;
    wr_addr = slot_idx;
    wr_data = '0;
    case (state)
      S_READ: begin
        rd_en = 1'b1;
      end
      S_CMP: begin
        mem_we        = !hit_now;
        wr_data.valid = 1'b1;
        wr_data.line  = line_q;
        wr_data.scan  = scan_q;
        wr_data.first = fill_first_q;
        wr_data.last  = fill_last_q;
      end
      S_WALK: begin
        rd_en         = walk_more;
        rd_addr       = walk_addr[SLOT_BITS-1:0];
        mem_we        = walk_match;
        wr_addr       = pend_addr;
        wr_data       = rd_q;
        wr_data.valid = 1'b0;
      end
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign res_nonblank = !res_first[COL_BITS-1] &&
                        ($signed(res_last) >= $signed(res_first));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      count         <= '0;
      slot_count    <= COUNT_BITS'(MAX_SLOTS);
      walk_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        // slot_count write drops every entry and restarts the sweep
        slot_count <= (cfg_wr_data > COUNT_BITS'(MAX_SLOTS)) ?
                      COUNT_BITS'(MAX_SLOTS) : cfg_wr_data;
        count      <= '0;
        clr_addr   <= '0;
        state      <= S_CLEAR;
      end else begin
        case (state)
          S_IDLE: begin
            if (s_axis_tvalid) begin
              mode_q       <= in_mode;
              line_q       <= in_line;
              scan_q       <= in_scan;
              fill_first_q <= in_first;
              fill_last_q  <= in_last;
              res_hit      <= 1'b0;
              // non-lookup results report blank bounds
              res_first    <= (in_mode == MODE_LOOKUP) ? in_first : '1;
              res_last     <= (in_mode == MODE_LOOKUP) ? in_last : '1;
              div_line     <= in_line;
              div_cnt      <= '0;
              rem          <= '0;
              walk_addr    <= '0;
              walk_pend    <= 1'b0;
              if (in_rfirst > in_rlast) begin
                range_lo <= in_rlast;
                range_hi <= in_rfirst;
              end else begin
                range_lo <= in_rfirst;
                range_hi <= in_rlast;
              end
              case (in_mode)
                MODE_LOOKUP: begin
                  state <= (slot_count == '0) ? S_RESULT : S_DIV;
                end
                MODE_RANGE: begin
                  state <= S_WALK;
                end
                MODE_CLEAR: begin
                  count <= '0;
                  state <= S_RESULT;
                end
                default: begin
                  state <= S_RESULT;
                end
              endcase
            end
          end
          S_DIV: begin
            rem      <= rem_next;
            div_line <= div_line << DIV_STEP;
            div_cnt  <= div_cnt + 1'b1;
            if (div_cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
              state <= S_READ;
            end
          end
          S_READ: begin
            state <= S_CMP;
          end
          S_CMP: begin
            if (hit_now) begin
              res_hit   <= 1'b1;
              res_first <= rd_q.first;
              res_last  <= rd_q.last;
            end else if (!rd_q.valid && (count < slot_count)) begin
              count <= count + 1'b1;
            end
            state <= S_RESULT;
          end
          S_WALK: begin
            if (walk_more) begin
              walk_pend <= 1'b1;
              pend_addr <= walk_addr[SLOT_BITS-1:0];
              walk_addr <= walk_addr + 1'b1;
            end else begin
              walk_pend <= 1'b0;
              if (!walk_pend) begin
                state <= S_RESULT;
              end
            end
            if (walk_match && (count != '0)) begin
              count <= count - 1'b1;
            end
          end
          S_RESULT: begin
            if (!m_axis_tvalid || m_axis_tready) begin
              m_axis_tdata <= {count, res_nonblank, res_last, res_first, res_hit};
              if (mode_q == MODE_CLEAR) begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end else begin
                state <= S_IDLE;
              end
            end
          end
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == SLOT_BITS'(MAX_SLOTS - 1)) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slot_count)
    else $error("valid count above slot count");

  a_cmp_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(rd_en) && ($past(rd_addr) == slot_idx)))
    else $error("compare without read of the mapped slot");

  a_walk_wb: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WALK) && mem_we) |-> ($past(rd_en) && ($past(rd_addr) == wr_addr)))
    else $error("invalidation write-back to a slot not read last cycle");

endmodule : line_bounds_direct_mapped_cache_unit
`default_nettype wire

>>> dv/line_bounds_direct_mapped_cache_unit_test.sv
// ----------------------------------------------------------------------------
// line_bounds_direct_mapped_cache_unit_test
// Self-checking bench for the line bounds cache. Lookups, range invalidations,
// clears and no-op items are sent over the input stream at several slot_count
// settings. Each accepted item runs through a local cache predictor, and every
// returned result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module line_bounds_direct_mapped_cache_unit_test
  import lbdmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mode_t                       mode;
    logic [LINE_BITS-1:0]        line;
    logic [SCAN_BITS-1:0]        scan;
    logic signed [COL_BITS-1:0]  fill_first;
    logic signed [COL_BITS-1:0]  fill_last;
    logic [LINE_BITS-1:0]        range_lo;
    logic [LINE_BITS-1:0]        range_hi;
  } bounds_req_t;

  typedef struct {
    bit                          hit;
    logic signed [COL_BITS-1:0]  first;
    logic signed [COL_BITS-1:0]  last;
    bit                          nonblank;
    logic [COUNT_BITS-1:0]       count;
  } bounds_res_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [COUNT_BITS-1:0]     cfg_wr_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
  logic [MODE_BITS-1:0]      s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;

  // predictor state
  entry_t       model_slot [MAX_SLOTS];
  int unsigned  model_slots_in_use = MAX_SLOTS;
  int unsigned  model_valid_total = 0;
  bounds_res_t  pending_bounds [$];

  // random traffic shaping
  logic [LINE_BITS-1:0]  pool_base;
  int unsigned           pool_span;
  logic [SCAN_BITS-1:0]  scan_a, scan_b;
  bit                    steady_flow = 1'b0;
  int unsigned           sink_hold = 0;

  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  hits_seen = 0;
  int unsigned  cfg_writes = 0;
  int unsigned  sent_by_mode [4] = '{0, 0, 0, 0};

  line_bounds_direct_mapped_cache_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic void drop_all_slots();
    foreach (model_slot[i]) model_slot[i].valid = 1'b0;
    model_valid_total = 0;
  endfunction

  function automatic bounds_res_t predict_bounds(bounds_req_t r);
    bounds_res_t           res;
    int unsigned           slot;
    logic [LINE_BITS-1:0]  lo, hi;
    res.hit      = 1'b0;
    res.first    = '1;
    res.last     = '1;
    res.nonblank = 1'b0;
    case (r.mode)
      MODE_LOOKUP: begin
        res.first = r.fill_first;
        res.last  = r.fill_last;
        if (model_slots_in_use != 0) begin
          slot = r.line % model_slots_in_use;
          if (model_slot[slot].valid && model_slot[slot].line == r.line &&
              model_slot[slot].scan == r.scan) begin
            res.hit = 1'b1;
          end else begin
            if (!model_slot[slot].valid && model_valid_total < model_slots_in_use)
              model_valid_total++;
            model_slot[slot].valid = 1'b1;
            model_slot[slot].line  = r.line;
            model_slot[slot].scan  = r.scan;
            model_slot[slot].first = r.fill_first;
            model_slot[slot].last  = r.fill_last;
          end
          res.first = model_slot[slot].first;
          res.last  = model_slot[slot].last;
        end
        res.nonblank = (res.first >= 0) && (res.last >= res.first);
      end
      MODE_RANGE: begin
        lo = r.range_lo;
        hi = r.range_hi;
        if (lo > hi) begin
          lo = r.range_hi;
          hi = r.range_lo;
        end
        for (int unsigned s = 0; s < model_slots_in_use; s++) begin
          if (model_slot[s].valid && model_slot[s].line >= lo && model_slot[s].line <= hi) begin
            model_slot[s].valid = 1'b0;
            if (model_valid_total > 0) model_valid_total--;
          end
        end
      end
      MODE_CLEAR: begin
        drop_all_slots();
      end
      default: ;
    endcase
    res.count = COUNT_BITS'(model_valid_total);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  // fields unused by the mode carry random junk
  function automatic bounds_req_t noise_req(mode_t m);
    bounds_req_t r;
    r.mode       = m;
    r.line       = LINE_BITS'($urandom);
    r.scan       = SCAN_BITS'($urandom_range(1, 240));
    r.fill_first = COL_BITS'($urandom_range(0, 240) - 1);
    r.fill_last  = COL_BITS'($urandom_range(0, 240) - 1);
    r.range_lo   = LINE_BITS'($urandom);
    r.range_hi   = LINE_BITS'($urandom);
    return r;
  endfunction

  function automatic bounds_req_t mk_lookup(int unsigned line, int unsigned scan,
                                            int first, int last);
    bounds_req_t r;
    r            = noise_req(MODE_LOOKUP);
    r.line       = LINE_BITS'(line);
    r.scan       = SCAN_BITS'(scan);
    r.fill_first = COL_BITS'(first);
    r.fill_last  = COL_BITS'(last);
    return r;
  endfunction

  function automatic bounds_req_t mk_range(int unsigned lo, int unsigned hi);
    bounds_req_t r;
    r          = noise_req(MODE_RANGE);
    r.range_lo = LINE_BITS'(lo);
    r.range_hi = LINE_BITS'(hi);
    return r;
  endfunction

  function automatic bounds_req_t random_req();
    bounds_req_t           r;
    int unsigned           pick;
    logic [LINE_BITS-1:0]  t;
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      r = noise_req(MODE_LOOKUP);
      if (pick < 78) begin
        // lines from a small pool so slots get reused; some alias onto a taken slot
        r.line = LINE_BITS'(pool_base + $urandom_range(0, pool_span));
        if ($urandom_range(0, 4) == 0)
          r.line = LINE_BITS'(r.line + model_slots_in_use * $urandom_range(1, 3));
        if ($urandom_range(0, 4) != 0) r.scan = $urandom_range(0, 1) ? scan_a : scan_b;
      end
    end else if (pick < 95) begin
      r = noise_req(MODE_RANGE);
      if ($urandom_range(0, 19) == 0) begin
        r.range_lo = '0;
        r.range_hi = '1;
      end else if ($urandom_range(0, 1)) begin
        r.range_lo = LINE_BITS'(pool_base + $urandom_range(0, pool_span));
        r.range_hi = LINE_BITS'(r.range_lo + $urandom_range(0, pool_span / 2));
      end
      if ($urandom_range(0, 1)) begin
        t          = r.range_lo;
        r.range_lo = r.range_hi;
        r.range_hi = t;
      end
    end else if (pick < 98) begin
      r = noise_req(MODE_CLEAR);
    end else begin
      r = noise_req(MODE_NONE);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus plumbing
  // --------------------------------------------------------------------------
  // leaves tvalid high after the transfer so back-to-back items need no re-raise
  task automatic send_request(bounds_req_t r);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= {6'b0, r.range_hi, r.range_lo, r.fill_last, r.fill_first,
                      r.scan, r.line};
    do @(posedge clk); while (!s_axis_tready);
    sent_by_mode[r.mode]++;
    pending_bounds.push_back(predict_bounds(r));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(int unsigned value);
    wait_drained();
    // a clear keeps sweeping the store after its result; let it finish
    repeat (2100) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[COUNT_BITS-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_slots_in_use = (value > MAX_SLOTS) ? MAX_SLOTS : value;
    drop_all_slots();
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    bounds_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit      = m_axis_tdata[0];
      got.first    = m_axis_tdata[9:1];
      got.last     = m_axis_tdata[18:10];
      got.nonblank = m_axis_tdata[19];
      got.count    = m_axis_tdata[31:20];
      if (pending_bounds.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", m_axis_tdata));
      end else begin
        want = pending_bounds.pop_front();
        check_field("hit", got.hit, want.hit);
        check_field("first_col", got.first, want.first);
        check_field("last_col", got.last, want.last);
        check_field("nonblank", got.nonblank, want.nonblank);
        check_field("valid_count", got.count, want.count);
        hits_seen += want.hit;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // default slot count straight out of reset
  task automatic test_reset_defaults();
    send_request(mk_lookup(0, 1, 0, 0));                // miss into empty slot
    send_request(mk_lookup(0, 1, 100, 100));            // hit returns stored bounds
    send_request(mk_lookup(0, 240, 5, 3));              // scan width differs, last < first
    send_request(mk_lookup('hFFFFFF, 240, 239, 239));
    send_request(mk_lookup(2048, 240, -1, -1));         // same slot as line 0, blank
    send_request(mk_lookup(2048, 240, 7, 9));
    send_request(mk_lookup(0, 240, 12, 200));
    send_request(mk_lookup(1, 17, 0, -1));
    send_request(mk_lookup('hFFFFFF, 240, 0, 0));
    send_request(mk_range('hFFFFFF, 1));                // reversed limits
    send_request(mk_lookup('hFFFFFF, 240, 3, 4));
    send_request(noise_req(MODE_NONE));
    send_request(noise_req(MODE_CLEAR));
    send_request(mk_lookup(0, 240, 12, 200));
  endtask

  task automatic test_bypass();
    write_slot_count(0);
    send_request(mk_lookup(5, 80, 3, 200));
    send_request(mk_lookup(5, 80, -1, 8));
    send_request(mk_range(0, 'hFFFFFF));
    send_request(noise_req(MODE_CLEAR));
    send_request(noise_req(MODE_NONE));
  endtask

  // register value above the slot array saturates to the full array
  task automatic test_saturated_count();
    write_slot_count(4095);
    send_request(mk_lookup(2047, 9, 1, 2));
    send_request(mk_lookup(4095, 9, 4, 6));
    send_request(mk_range(0, 'hFFFFFF));
  endtask

  task automatic test_single_slot();
    write_slot_count(1);
    send_request(mk_lookup(5, 33, 10, 20));
    send_request(mk_lookup(5, 33, 0, 0));
    send_request(mk_lookup(6, 33, 2, 2));
    send_request(mk_range(6, 6));
  endtask

  task automatic test_random_traffic(int unsigned value, int unsigned items);
    write_slot_count(value);
    pool_base = LINE_BITS'($urandom);
    pool_span = (model_slots_in_use == 0 || model_slots_in_use > 64) ?
                160 : 3 * model_slots_in_use + 4;
    scan_a    = SCAN_BITS'($urandom_range(1, 240));
    scan_b    = SCAN_BITS'($urandom_range(1, 240));
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_request(random_req());
    end
    steady_flow = 1'b0;
  endtask

  // output held off while input keeps offering, then the sender waits for drain
  task automatic test_output_stall();
    sink_hold   = 300;
    steady_flow = 1'b1;
    repeat (12) send_request(random_req());
    steady_flow = 1'b0;
    wait_drained();
  endtask

  initial begin
    drop_all_slots();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_bypass();
    test_saturated_count();
    test_single_slot();
    test_random_traffic(16, 280);
    test_output_stall();
    test_random_traffic(2048, 300);
    test_random_traffic(7, 250);
    test_random_traffic(1, 150);
    test_random_traffic(0, 100);
    test_random_traffic(300, 250);
    test_random_traffic(4095, 150);

    wait_drained();
    repeat (2100) @(posedge clk);
    if (pending_bounds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_bounds.size()));

    $display("Covered %0d lookups (%0d hits), %0d range invalidations, %0d clears, %0d no-ops",
             sent_by_mode[MODE_LOOKUP], hits_seen, sent_by_mode[MODE_RANGE],
             sent_by_mode[MODE_CLEAR], sent_by_mode[MODE_NONE]);
    $display("over %0d slot_count writes; %0d results compared, %0d mismatches",
             cfg_writes, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lbdmc_pkg.sv
rtl/line_bounds_direct_mapped_cache_unit.sv
dv/line_bounds_direct_mapped_cache_unit_test.sv
